// ===== rtl/cusa_pkg.sv =====
// shared constants, types and codes of the chunk unshuffle scatter address core
package cusa_pkg;

   // field widths
   localparam int DIM_WIDTH         = 16;
   localparam int MAX_ELEMENT_BYTES = 16;
   localparam int IDX_W             = 52;
   localparam int DATA_W            = 8;
   localparam int DIMS_W            = 2;
   localparam int EB_W              = 5;
   localparam int REG_IDX_W         = 3;
   localparam int CSR_W             = (DIM_WIDTH > EB_W) ? DIM_WIDTH : EB_W;

   // derived datapath widths
   localparam int LANE_W  = (MAX_ELEMENT_BYTES > 1) ? $clog2(MAX_ELEMENT_BYTES) : 1;
   localparam int PLANE_W = 2 * DIM_WIDTH;
   localparam int ELEMS_W = 3 * DIM_WIDTH;
   localparam int COORD_W = DIM_WIDTH + 1;
   localparam int REM_W   = (IDX_W > ELEMS_W + LANE_W) ? IDX_W : ELEMS_W + LANE_W;
   localparam int PX_W    = COORD_W + PLANE_W;
   localparam int PY_W    = COORD_W + DIM_WIDTH;
   localparam int LIN_W   = PX_W + 1;
   localparam int SCALE_W = LIN_W + EB_W;

   // divider pipeline stage map
   localparam int LANE_FIRST = 3;
   localparam int X_FIRST    = LANE_FIRST + LANE_W;
   localparam int Y_FIRST    = X_FIRST + DIM_WIDTH;
   localparam int DIV_STAGES = Y_FIRST + DIM_WIDTH;

   // register indexes
   typedef enum logic [REG_IDX_W-1:0] {
      REG_DIMENSIONALITY = 3'd0,
      REG_CHUNK_X        = 3'd1,
      REG_CHUNK_Y        = 3'd2,
      REG_CHUNK_Z        = 3'd3,
      REG_SIZE_X         = 3'd4,
      REG_SIZE_Y         = 3'd5,
      REG_SIZE_Z         = 3'd6,
      REG_ELEMENT_BYTES  = 3'd7
   } cusa_reg_type;

   // dataset dimensionality codes
   typedef enum logic [DIMS_W-1:0] {
      DIMS_NONE = 2'd0,
      DIMS_1D   = 2'd1,
      DIMS_2D   = 2'd2,
      DIMS_3D   = 2'd3
   } cusa_dims_type;

   // chunk and dataset geometry seen by the datapath
   typedef struct packed {
      cusa_dims_type          dims;
      logic                   cfg_ok;
      logic [ELEMS_W-1:0]     elems;
      logic [PLANE_W-1:0]     div_x;
      logic [DIM_WIDTH-1:0]   div_y;
      logic [PLANE_W-1:0]     mul_x;
      logic [DIM_WIDTH-1:0]   mul_y;
      logic [DIM_WIDTH-1:0]   size_x;
      logic [DIM_WIDTH-1:0]   size_y;
      logic [DIM_WIDTH-1:0]   size_z;
      logic [EB_W-1:0]        element_bytes;
   } cusa_geom_type;

   // transaction in flight through the divider stages
   typedef struct packed {
      logic [REM_W-1:0]     rem;
      logic [DIM_WIDTH-1:0] qx;
      logic [DIM_WIDTH-1:0] qy;
      logic [LANE_W-1:0]    lane;
      logic                 drop;
      logic [DIM_WIDTH-1:0] start_x;
      logic [DIM_WIDTH-1:0] start_y;
      logic [DIM_WIDTH-1:0] start_z;
      logic [DATA_W-1:0]    data;
   } cusa_div_type;

   // finished result
   typedef struct packed {
      logic [IDX_W-1:0]  dest_address;
      logic [DATA_W-1:0] write_data;
      logic              write_enable;
   } cusa_result_type;

endpackage

// ===== rtl/chunk_unshuffle_scatter_address_core.sv =====
// Shuffled-chunk scatter address core. Each transaction carries one byte of a decompressed,
// byte-shuffled chunk with its index in the chunk and the chunk origin; the result gives the
// row-major byte address in the dataset buffer, the byte, and a write enable that is low (with
// address zero) for bytes that fall outside the dataset or past the last lane. The core takes
// one transaction per clock while req_ready is high and returns results in order through three
// entry stages, one restoring-division stage per quotient bit (4 lane bits plus 16 bits each
// for the x and y splits), four address stages and the output register. A two-entry output
// buffer lets the core take a transaction while one result waits; req_ready drops only when
// both entries are full. The user must write registers through the csr port only while no
// transaction is in flight; the block does not enforce this. One may follow in the next cycle.
module chunk_unshuffle_scatter_address_core (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_we,
   input  logic [cusa_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [cusa_pkg::CSR_W-1:0]     csr_wdata,
   // request channel
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [cusa_pkg::IDX_W-1:0]     req_byte_index,
   input  logic [cusa_pkg::DIM_WIDTH-1:0] req_start_x,
   input  logic [cusa_pkg::DIM_WIDTH-1:0] req_start_y,
   input  logic [cusa_pkg::DIM_WIDTH-1:0] req_start_z,
   input  logic [cusa_pkg::DATA_W-1:0]    req_data_byte,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cusa_pkg::IDX_W-1:0]     rsp_dest_address,
   output logic [cusa_pkg::DATA_W-1:0]    rsp_write_data,
   output logic                           rsp_write_enable
);
   import cusa_pkg::*;

   cusa_geom_type   geom;
   cusa_div_type    req_item;
   cusa_div_type    div_item;
   logic            div_valid;
   cusa_result_type pipe_result;
   logic            pipe_valid;
   logic            pipe_en;
   logic            pipe_fire;
   logic            out_free;
   logic            rsp_valid_ff;
   logic            skid_valid_ff;
   cusa_result_type rsp_ff;
   cusa_result_type skid_ff;

   cusa_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   // incoming transaction
   always_comb begin
      req_item         = '0;
      req_item.rem     = REM_W'(req_byte_index);
      req_item.start_x = req_start_x;
      req_item.start_y = req_start_y;
      req_item.start_z = req_start_z;
      req_item.data    = req_data_byte;
   end

   cusa_divpipe u_divpipe (
      .clock     (clock),
      .reset     (reset),
      .pipe_en   (pipe_en),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .geom      (geom),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   cusa_addr u_addr (
      .clock      (clock),
      .reset      (reset),
      .pipe_en    (pipe_en),
      .in_valid   (div_valid),
      .in_item    (div_item),
      .geom       (geom),
      .out_valid  (pipe_valid),
      .out_result (pipe_result)
   );

   // pipeline moves unless the spare output entry is taken
   assign pipe_en   = !skid_valid_ff;
   assign req_ready = pipe_en;
   assign pipe_fire = pipe_en & pipe_valid;
   assign out_free  = !rsp_valid_ff | rsp_ready;

   // output register and skid entry control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff  <= skid_valid_ff | pipe_fire;
         skid_valid_ff <= 1'b0;
      end else if (pipe_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output register and skid entry payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : pipe_result;
      end else if (pipe_fire) begin
         skid_ff <= pipe_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_dest_address = rsp_ff.dest_address;
   assign rsp_write_data   = rsp_ff.write_data;
   assign rsp_write_enable = rsp_ff.write_enable;

endmodule

// ===== rtl/cusa_cfg.sv =====
// configuration registers and derived chunk geometry
module cusa_cfg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [cusa_pkg::REG_IDX_W-1:0] csr_index,
   input  logic [cusa_pkg::CSR_W-1:0]     csr_wdata,
   output cusa_pkg::cusa_geom_type       geom
);
   import cusa_pkg::*;

   cusa_dims_type        dims_ff;
   logic [DIM_WIDTH-1:0] chunk_x_ff, chunk_y_ff, chunk_z_ff;
   logic [DIM_WIDTH-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [EB_W-1:0]      element_bytes_ff;

   logic [PLANE_W-1:0]   cxy_ff;
   logic [PLANE_W-1:0]   div_x_ff, div_x_in;
   logic [DIM_WIDTH-1:0] div_y_ff, div_y_in;
   logic [PLANE_W-1:0]   mul_x_ff, mul_x_in;
   logic [DIM_WIDTH-1:0] mul_y_ff, mul_y_in;
   logic                 cfg_ok_ff, cfg_ok_in;
   logic [ELEMS_W-1:0]   elems_ff, elems_in;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff          <= DIMS_1D;
         chunk_x_ff       <= DIM_WIDTH'(1);
         chunk_y_ff       <= DIM_WIDTH'(1);
         chunk_z_ff       <= DIM_WIDTH'(1);
         size_x_ff        <= '0;
         size_y_ff        <= '0;
         size_z_ff        <= '0;
         element_bytes_ff <= EB_W'(1);
      end else if (csr_we) begin
         case (cusa_reg_type'(csr_index))
            REG_DIMENSIONALITY: dims_ff          <= cusa_dims_type'(csr_wdata[DIMS_W-1:0]);
            REG_CHUNK_X:        chunk_x_ff       <= csr_wdata[DIM_WIDTH-1:0];
            REG_CHUNK_Y:        chunk_y_ff       <= csr_wdata[DIM_WIDTH-1:0];
            REG_CHUNK_Z:        chunk_z_ff       <= csr_wdata[DIM_WIDTH-1:0];
            REG_SIZE_X:         size_x_ff        <= csr_wdata[DIM_WIDTH-1:0];
            REG_SIZE_Y:         size_y_ff        <= csr_wdata[DIM_WIDTH-1:0];
            REG_SIZE_Z:         size_z_ff        <= csr_wdata[DIM_WIDTH-1:0];
            REG_ELEMENT_BYTES:  element_bytes_ff <= csr_wdata[EB_W-1:0];
            default: ;
         endcase
      end
   end

   // divisors and row strides per dimensionality
   always_comb begin
      case (dims_ff)
         DIMS_3D: begin
            div_x_in = PLANE_W'(chunk_y_ff) * PLANE_W'(chunk_z_ff);
            div_y_in = chunk_z_ff;
            mul_x_in = PLANE_W'(size_y_ff) * PLANE_W'(size_z_ff);
            mul_y_in = size_z_ff;
         end
         DIMS_2D: begin
            div_x_in = PLANE_W'(chunk_y_ff);
            div_y_in = DIM_WIDTH'(1);
            mul_x_in = PLANE_W'(size_y_ff);
            mul_y_in = DIM_WIDTH'(1);
         end
         default: begin
            div_x_in = PLANE_W'(1);
            div_y_in = DIM_WIDTH'(1);
            mul_x_in = PLANE_W'(1);
            mul_y_in = DIM_WIDTH'(1);
         end
      endcase
   end

   // usable layout: dimensions set, element size in range, no zero chunk extent in use
   assign cfg_ok_in = (dims_ff != DIMS_NONE) && (element_bytes_ff != '0) &&
                      (32'(element_bytes_ff) <= 32'(MAX_ELEMENT_BYTES)) &&
                      (chunk_x_ff != '0) &&
                      ((dims_ff == DIMS_1D) || (chunk_y_ff != '0)) &&
                      ((dims_ff != DIMS_3D) || (chunk_z_ff != '0));

   // elements per chunk, second multiply step
   always_comb begin
      case (dims_ff)
         DIMS_3D: elems_in = ELEMS_W'(cxy_ff) * ELEMS_W'(chunk_z_ff);
         DIMS_2D: elems_in = ELEMS_W'(cxy_ff);
         default: elems_in = ELEMS_W'(chunk_x_ff);
      endcase
   end

   // derived geometry registers
   always_ff @(posedge clock) begin
      cxy_ff    <= PLANE_W'(chunk_x_ff) * PLANE_W'(chunk_y_ff);
      div_x_ff  <= div_x_in;
      div_y_ff  <= div_y_in;
      mul_x_ff  <= mul_x_in;
      mul_y_ff  <= mul_y_in;
      cfg_ok_ff <= cfg_ok_in;
      elems_ff  <= elems_in;
   end

   assign geom.dims          = dims_ff;
   assign geom.cfg_ok        = cfg_ok_ff;
   assign geom.elems         = elems_ff;
   assign geom.div_x         = div_x_ff;
   assign geom.div_y         = div_y_ff;
   assign geom.mul_x         = mul_x_ff;
   assign geom.mul_y         = mul_y_ff;
   assign geom.size_x        = size_x_ff;
   assign geom.size_y        = size_y_ff;
   assign geom.size_z        = size_z_ff;
   assign geom.element_bytes = element_bytes_ff;

endmodule

// ===== rtl/cusa_divpipe.sv =====
// restoring divider pipeline: lane, x and y quotients, one bit per stage
module cusa_divpipe (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pipe_en,
   input  logic                    in_valid,
   input  cusa_pkg::cusa_div_type  in_item,
   input  cusa_pkg::cusa_geom_type geom,
   output logic                    out_valid,
   output cusa_pkg::cusa_div_type  out_item
);
   import cusa_pkg::*;

   logic [DIV_STAGES-1:0] valid_ff;
   cusa_div_type          item_ff [DIV_STAGES];
   cusa_div_type          item_in [DIV_STAGES];

   // next value of every stage
   always_comb begin
      logic [REM_W-1:0] sub;
      int               k;

      // entry register
      item_in[0] = in_item;

      // unusable layout drops the transaction
      item_in[1] = item_ff[0];
      item_in[1].drop = item_ff[0].drop | !geom.cfg_ok;

      // index past the last lane of the widest element
      item_in[2] = item_ff[1];
      sub = REM_W'(geom.elems) << LANE_W;
      if (item_ff[1].rem >= sub) begin
         item_in[2].drop = 1'b1;
      end

      // lane = index / elements per chunk
      for (int j = 0; j < LANE_W; j++) begin
         k = LANE_W - 1 - j;
         item_in[LANE_FIRST + j] = item_ff[LANE_FIRST + j - 1];
         sub = REM_W'(geom.elems) << k;
         if (item_ff[LANE_FIRST + j - 1].rem >= sub) begin
            item_in[LANE_FIRST + j].rem     = item_ff[LANE_FIRST + j - 1].rem - sub;
            item_in[LANE_FIRST + j].lane[k] = 1'b1;
         end
      end

      // x = element / (chunk_y * chunk_z)
      for (int j = 0; j < DIM_WIDTH; j++) begin
         k = DIM_WIDTH - 1 - j;
         item_in[X_FIRST + j] = item_ff[X_FIRST + j - 1];
         sub = REM_W'(geom.div_x) << k;
         if (item_ff[X_FIRST + j - 1].rem >= sub) begin
            item_in[X_FIRST + j].rem   = item_ff[X_FIRST + j - 1].rem - sub;
            item_in[X_FIRST + j].qx[k] = 1'b1;
         end
      end

      // y = rest / chunk_z, z is what remains
      for (int j = 0; j < DIM_WIDTH; j++) begin
         k = DIM_WIDTH - 1 - j;
         item_in[Y_FIRST + j] = item_ff[Y_FIRST + j - 1];
         sub = REM_W'(geom.div_y) << k;
         if (item_ff[Y_FIRST + j - 1].rem >= sub) begin
            item_in[Y_FIRST + j].rem   = item_ff[Y_FIRST + j - 1].rem - sub;
            item_in[Y_FIRST + j].qy[k] = 1'b1;
         end
      end
   end

   // valid bits travel with the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            item_ff[s] <= item_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_item  = item_ff[DIV_STAGES-1];

endmodule

// ===== rtl/cusa_addr.sv =====
// coordinate offset, bounds check and row-major address stages
module cusa_addr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       pipe_en,
   input  logic                       in_valid,
   input  cusa_pkg::cusa_div_type     in_item,
   input  cusa_pkg::cusa_geom_type    geom,
   output logic                       out_valid,
   output cusa_pkg::cusa_result_type  out_result
);
   import cusa_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [LANE_W-1:0]  lane;
      logic               drop;
      logic [DATA_W-1:0]  data;
   } coord_type;

   typedef struct packed {
      logic [PX_W-1:0]    px;
      logic [PY_W-1:0]    py;
      logic [COORD_W-1:0] z;
      logic [LANE_W-1:0]  lane;
      logic               drop;
      logic [DATA_W-1:0]  data;
   } prod_type;

   typedef struct packed {
      logic [LIN_W-1:0]  lin;
      logic [LANE_W-1:0] lane;
      logic              drop;
      logic [DATA_W-1:0] data;
   } lin_type;

   logic [3:0]         valid_ff;
   coord_type          coord_ff, coord_in;
   prod_type           prod_ff, prod_in;
   lin_type            lin_ff, lin_in;
   cusa_result_type    result_ff, result_in;
   logic               inb_x, inb_y, inb_z, lane_bad;
   logic [SCALE_W-1:0] scaled;

   // chunk origin plus local coordinate, checked against the dataset extent
   always_comb begin
      coord_in.x = COORD_W'(in_item.qx) + COORD_W'(in_item.start_x);
      coord_in.y = ((geom.dims == DIMS_2D) || (geom.dims == DIMS_3D)) ?
                   COORD_W'(in_item.qy) + COORD_W'(in_item.start_y) : '0;
      coord_in.z = (geom.dims == DIMS_3D) ?
                   COORD_W'(in_item.rem[DIM_WIDTH-1:0]) + COORD_W'(in_item.start_z) : '0;
      inb_x    = coord_in.x < COORD_W'(geom.size_x);
      inb_y    = (geom.dims == DIMS_1D) || (coord_in.y < COORD_W'(geom.size_y));
      inb_z    = (geom.dims != DIMS_3D) || (coord_in.z < COORD_W'(geom.size_z));
      lane_bad = 32'(in_item.lane) >= 32'(geom.element_bytes);
      coord_in.lane = in_item.lane;
      coord_in.data = in_item.data;
      coord_in.drop = in_item.drop | lane_bad | !(inb_x & inb_y & inb_z);
   end

   // row strides
   always_comb begin
      prod_in.px   = PX_W'(coord_ff.x) * PX_W'(geom.mul_x);
      prod_in.py   = PY_W'(coord_ff.y) * PY_W'(geom.mul_y);
      prod_in.z    = coord_ff.z;
      prod_in.lane = coord_ff.lane;
      prod_in.drop = coord_ff.drop;
      prod_in.data = coord_ff.data;
   end

   // linear element number
   always_comb begin
      lin_in.lin  = LIN_W'(prod_ff.px) + LIN_W'(prod_ff.py) + LIN_W'(prod_ff.z);
      lin_in.lane = prod_ff.lane;
      lin_in.drop = prod_ff.drop;
      lin_in.data = prod_ff.data;
   end

   // byte address: element number times element size plus lane
   always_comb begin
      scaled = SCALE_W'(lin_ff.lin) * SCALE_W'(geom.element_bytes) + SCALE_W'(lin_ff.lane);
      result_in.dest_address = lin_ff.drop ? '0 : IDX_W'(scaled);
      result_in.write_enable = !lin_ff.drop;
      result_in.write_data   = lin_ff.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         coord_ff  <= coord_in;
         prod_ff   <= prod_in;
         lin_ff    <= lin_in;
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff[3];
   assign out_result = result_ff;

endmodule

// ===== rtl/cusa_checker.sv =====
// port-level checks for the chunk unshuffle scatter address core
module cusa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           csr_we,
   input logic [cusa_pkg::REG_IDX_W-1:0] csr_index,
   input logic [cusa_pkg::CSR_W-1:0]     csr_wdata,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [cusa_pkg::IDX_W-1:0]     req_byte_index,
   input logic [cusa_pkg::DIM_WIDTH-1:0] req_start_x,
   input logic [cusa_pkg::DIM_WIDTH-1:0] req_start_y,
   input logic [cusa_pkg::DIM_WIDTH-1:0] req_start_z,
   input logic [cusa_pkg::DATA_W-1:0]    req_data_byte,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cusa_pkg::IDX_W-1:0]     rsp_dest_address,
   input logic [cusa_pkg::DATA_W-1:0]    rsp_write_data,
   input logic                           rsp_write_enable
);
   import cusa_pkg::*;

   // no result shows right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_address) &&
                                  $stable(rsp_write_data) && $stable(rsp_write_enable))
      else $error("stalled response changed");

   // dropped byte carries address zero
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_enable |-> rsp_dest_address == '0)
      else $error("dropped byte with nonzero address");

   // input backpressure only while a result waits at the output
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty output");

   // taking the waiting result reopens the request side
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      !req_ready && rsp_ready |=> req_ready)
      else $error("request side stays stalled after response taken");

endmodule

bind chunk_unshuffle_scatter_address_core cusa_checker u_cusa_checker (.*);
